@@ rtl/core/mer_pkg.sv @@
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD1,
		ST_LD2,
		ST_LD3,
		ST_LD4,
		ST_ADV,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_E6
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_LD1,
		OP_LD2,
		OP_LD3,
		OP_LD4,
		OP_ADV,
		OP_E1,
		OP_E2,
		OP_E3,
		OP_E4,
		OP_E5,
		OP_E6
	} dp_op_t;

	typedef struct packed {
		logic out_free;
		logic active;
		logic fin;
		logic to_r2;
	} dp_status_t;

endpackage

@@ rtl/core/mer_ctrl.sv @@
// Sequencer for the ellipse rasterizer: accepts items and steps the datapath.
module mer_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                mode,
	input  mer_pkg::dp_status_t status,
	output logic                in_stall,
	output mer_pkg::dp_op_t     op
);
	import mer_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !status.out_free;
				if (in_valid && status.out_free) begin
					op = OP_TAKE;
					if (mode == MODE_LOAD) begin
						state_nxt = ST_LD1;
					end else if (status.active && !status.fin) begin
						state_nxt = ST_ADV;
					end
				end
			end
			ST_LD1: begin
				op        = OP_LD1;
				state_nxt = ST_LD2;
			end
			ST_LD2: begin
				op        = OP_LD2;
				state_nxt = ST_LD3;
			end
			ST_LD3: begin
				op        = OP_LD3;
				state_nxt = ST_LD4;
			end
			ST_LD4: begin
				op        = OP_LD4;
				state_nxt = ST_ADV;
			end
			ST_ADV: begin
				op        = OP_ADV;
				state_nxt = status.to_r2 ? ST_E1 : ST_IDLE;
			end
			ST_E1: begin
				op        = OP_E1;
				state_nxt = ST_E2;
			end
			ST_E2: begin
				op        = OP_E2;
				state_nxt = ST_E3;
			end
			ST_E3: begin
				op        = OP_E3;
				state_nxt = ST_E4;
			end
			ST_E4: begin
				op        = OP_E4;
				state_nxt = ST_E5;
			end
			ST_E5: begin
				op        = OP_E5;
				state_nxt = ST_E6;
			end
			ST_E6: begin
				op        = OP_E6;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/mer_dp.sv @@
// Datapath for the ellipse rasterizer: point state, decision terms, multiplier, output register.
module mer_dp #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mer_pkg::dp_op_t               op,
	input  logic                          mode,
	input  logic [COORD_BITS-1:0]         center_x,
	input  logic [COORD_BITS-1:0]         center_y,
	input  logic [COORD_BITS-2:0]         radius_x,
	input  logic [COORD_BITS-2:0]         radius_y,
	input  logic                          out_stall,
	output mer_pkg::dp_status_t           status,
	output logic                          out_valid,
	output logic signed [COORD_BITS+1:0]  right_x,
	output logic signed [COORD_BITS+1:0]  left_x,
	output logic signed [COORD_BITS+1:0]  lower_y,
	output logic signed [COORD_BITS+1:0]  upper_y,
	output logic                          point_valid,
	output logic                          last
);
	import mer_pkg::*;

	localparam int RAD_W = COORD_BITS - 1;
	localparam int X_W   = COORD_BITS;
	localparam int OUT_W = COORD_BITS + 2;
	localparam int SQ_W  = 2 * RAD_W;
	localparam int MUL_W = 2 * RAD_W + 2;
	localparam int DEC_W = 2 * MUL_W;

	// held ellipse
	logic [COORD_BITS-1:0] held_cx_q, held_cy_q;
	logic [RAD_W-1:0]      held_rx_q, held_ry_q;
	logic [SQ_W-1:0]       a2_q, b2_q;

	// walk state
	logic [X_W-1:0]   x_q;
	logic [RAD_W-1:0] y_q;
	logic             r2_q, active_q;

	// 4x-scaled decision and its running terms
	// gx = 8b2(x+1), hx = gx + 4b2, fy = 8a2 y, gy = 8a2(y-1), hy = gy - 4a2
	logic signed [DEC_W-1:0] dec_q, gx_q, hx_q, fy_q, gy_q, hy_q;

	logic [DEC_W-1:0] p_q, mul_p;
	logic [MUL_W-1:0] mul_a, mul_b;

	logic [OUT_W-1:0] right_q, left_q, lower_q, upper_q;
	logic             out_valid_q, pv_q, last_q;

	logic                    take, load, le, fin, to_r2, valid_now, last_now;
	logic [RAD_W-1:0]        rx_in, ry_in, ty_abs;
	logic [X_W:0]            tx;
	logic [OUT_W-1:0]        ocx, ocy, ox, oy;
	logic signed [DEC_W-1:0] a2w, b2w, pw;

	assign take  = (op == OP_TAKE);
	assign load  = (mode == MODE_LOAD);
	assign rx_in = (radius_x == '0) ? RAD_W'(1) : radius_x;
	assign ry_in = (radius_y == '0) ? RAD_W'(1) : radius_y;

	assign le    = (dec_q == '0) || dec_q[DEC_W-1];
	assign fin   = r2_q && (y_q == '0);
	assign to_r2 = !r2_q && (gx_q >= (le ? fy_q : gy_q));

	assign status.out_free = !out_valid_q || !out_stall;
	assign status.active   = active_q;
	assign status.fin      = fin;
	assign status.to_r2    = to_r2;

	assign a2w = signed'(DEC_W'(a2_q));
	assign b2w = signed'(DEC_W'(b2_q));
	assign pw  = signed'(p_q);

	assign tx     = {x_q, 1'b1};
	assign ty_abs = (y_q == '0) ? RAD_W'(1) : y_q - RAD_W'(1);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_LD1: begin
				mul_a = MUL_W'(held_rx_q);
				mul_b = MUL_W'(held_rx_q);
			end
			OP_LD2: begin
				mul_a = MUL_W'(held_ry_q);
				mul_b = MUL_W'(held_ry_q);
			end
			OP_LD3: begin
				mul_a = MUL_W'(a2_q);
				mul_b = MUL_W'(held_ry_q);
			end
			OP_E1: begin
				mul_a = MUL_W'(tx);
				mul_b = MUL_W'(tx);
			end
			OP_E2: begin
				mul_a = MUL_W'(b2_q);
				mul_b = p_q[MUL_W-1:0];
			end
			OP_E3: begin
				mul_a = MUL_W'(a2_q);
				mul_b = MUL_W'(b2_q);
			end
			OP_E4: begin
				mul_a = MUL_W'(ty_abs);
				mul_b = MUL_W'(ty_abs);
			end
			OP_E5: begin
				mul_a = MUL_W'(a2_q);
				mul_b = p_q[MUL_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// result of the item being accepted
	always_comb begin
		valid_now = load || active_q;
		last_now  = !load && active_q && fin;
		ocx       = load ? OUT_W'(center_x) : OUT_W'(held_cx_q);
		ocy       = load ? OUT_W'(center_y) : OUT_W'(held_cy_q);
		ox        = load ? '0 : OUT_W'(x_q);
		oy        = load ? OUT_W'(ry_in) : OUT_W'(y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			r2_q        <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (load) begin
					active_q <= 1'b1;
					r2_q     <= 1'b0;
				end else if (active_q && fin) begin
					active_q <= 1'b0;
				end
			end
			if (op == OP_ADV && to_r2) begin
				r2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_p;
		if (take) begin
			if (valid_now) begin
				right_q <= ocx + ox;
				left_q  <= ocx - ox;
				lower_q <= ocy + oy;
				upper_q <= ocy - oy;
			end else begin
				right_q <= '0;
				left_q  <= '0;
				lower_q <= '0;
				upper_q <= '0;
			end
			pv_q   <= valid_now;
			last_q <= last_now;
		end
		unique case (op)
			OP_TAKE: begin
				if (load) begin
					held_cx_q <= center_x;
					held_cy_q <= center_y;
					held_rx_q <= rx_in;
					held_ry_q <= ry_in;
					x_q       <= '0;
					y_q       <= ry_in;
				end
			end
			OP_LD2: begin
				a2_q <= p_q[SQ_W-1:0];
			end
			OP_LD3: begin
				b2_q <= p_q[SQ_W-1:0];
			end
			OP_LD4: begin
				fy_q  <= pw <<< 3;
				gy_q  <= (pw <<< 3) - (a2w <<< 3);
				hy_q  <= (pw <<< 3) - (a2w <<< 3) - (a2w <<< 2);
				gx_q  <= b2w <<< 3;
				hx_q  <= (b2w <<< 3) + (b2w <<< 2);
				dec_q <= (b2w <<< 2) + a2w - (pw <<< 2);
			end
			OP_ADV: begin
				if (!r2_q) begin
					x_q  <= x_q + X_W'(1);
					gx_q <= gx_q + (b2w <<< 3);
					hx_q <= hx_q + (b2w <<< 3);
					if (le) begin
						dec_q <= dec_q + hx_q;
					end else begin
						y_q   <= y_q - RAD_W'(1);
						fy_q  <= gy_q;
						gy_q  <= gy_q - (a2w <<< 3);
						hy_q  <= hy_q - (a2w <<< 3);
						dec_q <= dec_q + hx_q - gy_q;
					end
				end else begin
					y_q  <= y_q - RAD_W'(1);
					fy_q <= gy_q;
					gy_q <= gy_q - (a2w <<< 3);
					hy_q <= hy_q - (a2w <<< 3);
					if (le) begin
						x_q   <= x_q + X_W'(1);
						gx_q  <= gx_q + (b2w <<< 3);
						hx_q  <= hx_q + (b2w <<< 3);
						dec_q <= dec_q + gx_q - hy_q;
					end else begin
						dec_q <= dec_q - hy_q;
					end
				end
			end
			OP_E3: begin
				dec_q <= pw;
			end
			OP_E4: begin
				dec_q <= dec_q - (pw <<< 2);
			end
			OP_E6: begin
				dec_q <= dec_q + (pw <<< 2);
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign right_x     = signed'(right_q);
	assign left_x      = signed'(left_q);
	assign lower_y     = signed'(lower_q);
	assign upper_y     = signed'(upper_q);
	assign point_valid = pv_q;
	assign last        = last_q;

endmodule

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | mode, center_x, center_y, radius_x, radius_y
//  out     | out_valid/out_stall | right_x, left_x, lower_y, upper_y,
//          |                     | point_valid, last
//
// One item in flight; its result is registered at acceptance. A step item is
// accepted and makes one decision update; one entering region two forms its
// start decision in five passes of the shared multiplier and an add. A load
// item is accepted, forms the radius squares and a2*b on the same multiplier,
// makes its first update and, if that enters region two, the start decision.
// A final or idle step is only accepted. Reset clears control only. in_stall
// is high while a sequence runs or the output register holds an untaken item.
module midpoint_ellipse_rasterizer #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-2:0]        radius_x,
	input  logic [COORD_BITS-2:0]        radius_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS+1:0] right_x,
	output logic signed [COORD_BITS+1:0] left_x,
	output logic signed [COORD_BITS+1:0] lower_y,
	output logic signed [COORD_BITS+1:0] upper_y,
	output logic                         point_valid,
	output logic                         last
);
	import mer_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.status   (status),
		.in_stall (in_stall),
		.op       (op)
	);

	mer_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.mode        (mode),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius_x    (radius_x),
		.radius_y    (radius_y),
		.out_stall   (out_stall),
		.status      (status),
		.out_valid   (out_valid),
		.right_x     (right_x),
		.left_x      (left_x),
		.lower_y     (lower_y),
		.upper_y     (upper_y),
		.point_valid (point_valid),
		.last        (last)
	);

endmodule
